>>> rtl/case_folding_subsequence_match_assert.svh
// Assertion macros for the case-folding subsequence matcher checker.
`ifndef CASE_FOLDING_SUBSEQUENCE_MATCH_ASSERT_SVH
`define CASE_FOLDING_SUBSEQUENCE_MATCH_ASSERT_SVH

// Clocked assertion, quiet while reset is asserted.
`define CFSM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define CFSM_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> rtl/cfsm_pkg.sv
// Types and constants shared by the case-folding subsequence matcher.
`timescale 1ns / 1ps

package cfsm_pkg;

    localparam int MAX_LEN_DEF = 63;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_TEXT   = 2'd2,
        CMD_END    = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] ch;
    } in_t;

    typedef struct packed {
        logic match;
        logic overflow;
    } out_t;

endpackage

>>> rtl/cfsm_row_update.sv
// DP row update for one text byte: all pattern positions compared in parallel.
`timescale 1ns / 1ps

module cfsm_row_update #(
    parameter int MAX_LEN = cfsm_pkg::MAX_LEN_DEF,
    localparam int LEN_W  = $clog2(MAX_LEN + 1),
    localparam int ROW_W  = MAX_LEN + 1
) (
    input  logic [7:0]       store [MAX_LEN],
    input  logic [LEN_W-1:0] len,
    input  logic [ROW_W-1:0] row,
    input  logic [7:0]       ch,
    output logic [ROW_W-1:0] row_next
);
    import cfsm_pkg::*;

    logic             is_lower;
    logic [7:0]       key;
    logic [ROW_W-1:0] eq_mask;
    logic [ROW_W-1:0] shifted;

    assign is_lower = (ch >= 8'd97) && (ch <= 8'd122);
    assign key      = is_lower ? (ch - 8'd32) : ch;
    assign shifted  = {row[ROW_W-2:0], 1'b0};

    // Bit j set when pattern byte j-1 equals the key and j lies within the pattern.
    always_comb begin
        eq_mask = '0;
        for (int j = 1; j < ROW_W; j++) begin
            eq_mask[j] = (store[j-1] == key) && (LEN_W'(j) <= len);
        end
    end

    assign row_next = is_lower ? (row | (shifted & eq_mask)) : (shifted & eq_mask);

endmodule

>>> rtl/case_folding_subsequence_match.sv
// Top level of the case-folding subsequence matcher.
//
//  channel | ports                     | payload      | carries
//  --------+---------------------------+--------------+------------------------------
//  input   | s_valid s_ready s_data    | cfsm_pkg::in_t  | command and byte
//  result  | m_valid m_ready m_data    | cfsm_pkg::out_t | match and overflow flags
//
// One transfer per cycle is taken while no end-of-text command waits; each command is
// held in the input register and executed from there, and a result is registered in
// the result register once its end-of-text command executes.
// The DP row update is a single pass over all pattern lanes, which sets the rate.
// Reset clears length, overflow flag and both valid flags, and sets the row to bit 0 only.
// An end-of-text command waits in the input register while a result is not taken.
`timescale 1ns / 1ps

module case_folding_subsequence_match #(
    parameter int MAX_LEN = cfsm_pkg::MAX_LEN_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  cfsm_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output cfsm_pkg::out_t m_data
);
    import cfsm_pkg::*;

    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam int ROW_W = MAX_LEN + 1;
    localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    logic [7:0]       store_reg [MAX_LEN];
    in_t              in_reg;
    logic             in_vld_reg;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             too_long_reg, too_long_next;
    logic             m_vld_reg, m_vld_next;
    out_t             m_data_reg, m_data_next;
    logic [ROW_W-1:0] row_text;
    logic             advance;
    logic             store_we;

    cfsm_row_update #(
        .MAX_LEN (MAX_LEN)
    ) u_row (
        .store    (store_reg),
        .len      (len_reg),
        .row      (row_reg),
        .ch       (in_reg.ch),
        .row_next (row_text)
    );

    assign advance = in_vld_reg && !((in_reg.cmd == CMD_END) && m_vld_reg && !m_ready);
    assign s_ready = !in_vld_reg || advance;
    assign m_valid = m_vld_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        len_next      = len_reg;
        row_next      = row_reg;
        too_long_next = too_long_reg;
        m_vld_next    = m_vld_reg && !m_ready;
        m_data_next   = m_data_reg;
        store_we      = 1'b0;
        if (advance) begin
            case (in_reg.cmd)
                CMD_CLEAR: begin
                    len_next      = '0;
                    too_long_next = 1'b0;
                    row_next      = ROW_W'(1);
                end
                CMD_APPEND: begin
                    if (len_reg < LEN_W'(MAX_LEN)) begin
                        store_we = 1'b1;
                        len_next = len_reg + LEN_W'(1);
                    end else begin
                        too_long_next = 1'b1;
                    end
                    row_next = ROW_W'(1);
                end
                CMD_TEXT: begin
                    row_next = row_text;
                end
                CMD_END: begin
                    m_vld_next           = 1'b1;
                    m_data_next.match    = row_reg[len_reg] && !too_long_reg;
                    m_data_next.overflow = too_long_reg;
                    row_next             = ROW_W'(1);
                end
                default: begin
                    row_next = row_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg   <= 1'b0;
            len_reg      <= '0;
            row_reg      <= ROW_W'(1);
            too_long_reg <= 1'b0;
            m_vld_reg    <= 1'b0;
        end else begin
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            len_reg      <= len_next;
            row_reg      <= row_next;
            too_long_reg <= too_long_next;
            m_vld_reg    <= m_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (store_we) begin
            store_reg[len_reg[IDX_W-1:0]] <= in_reg.ch;
        end
    end

endmodule

>>> rtl/cfsm_checker.sv
// Port-level checker for the case-folding subsequence matcher, with its bind.
`timescale 1ns / 1ps
`include "case_folding_subsequence_match_assert.svh"

module cfsm_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input cfsm_pkg::in_t  s_data,
    input logic           m_valid,
    input logic           m_ready,
    input cfsm_pkg::out_t m_data
);
    import cfsm_pkg::*;

    // A stalled result keeps its flags.
    `CFSM_ASSERT(a_result_hold, m_valid && !m_ready |=> m_valid && $stable(m_data), "result dropped or changed while stalled")

    // An overflowed pattern never reports a match.
    `CFSM_ASSERT(a_no_match_on_overflow, m_valid |-> !(m_data.match && m_data.overflow), "match reported with overflow")

    // Reset leaves no result on offer.
    `CFSM_ASSERT_RST(a_reset_clears, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind case_folding_subsequence_match cfsm_checker u_cfsm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
